// File: rtl/core/sorted_insert_list_core_assert.svh
// assertion macros shared by the sorted insert list checker
// expects a clock named clk and an active-high reset named rst in scope
`ifndef SORTED_INSERT_LIST_CORE_ASSERT_SVH
`define SORTED_INSERT_LIST_CORE_ASSERT_SVH

// same-cycle implication, off during reset
`define SIL_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted insert list check failed");

// next-cycle implication, off during reset
`define SIL_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted insert list check failed");

`endif

// File: rtl/core/sil_pkg.sv
// package for the sorted insert list: sizes, codes, fsm and cell control types
// no dependencies
package sil_pkg;

  localparam int DEPTH   = 16;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;
  localparam int STAT_W  = 2;

  localparam logic CMD_INSERT  = 1'b0;
  localparam logic CMD_DISPLAY = 1'b1;

  localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_DISP
  } state_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_ROTATE
  } cell_op_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    cell_op_t                   op;
    logic signed [VALUE_W-1:0]  value;
    logic        [CNT_W-1:0]    count;
  } chain_ctl_t;

endpackage

// File: rtl/core/sil_channels.sv
// valid/ready channel interfaces for the sorted insert list
// depends on sil_pkg
interface sil_req_if;
  import sil_pkg::*;
  logic                      valid;
  logic                      ready;
  logic                      command;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface sil_rsp_if;
  import sil_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] entry_value;
  logic                      last;
  logic [STAT_W-1:0]         status;
  logic [COUNT_W-1:0]        count;

  modport source (output valid, output entry_value, output last, output status,
                  output count, input ready);
  modport sink   (input valid, input entry_value, input last, input status,
                  input count, output ready);
endinterface

// File: rtl/core/sil_cell.sv
// one storage cell of the sorted chain: compare, shift in from the left on
// insert, take from the right (or wrap the head) on rotate; depends on sil_pkg
module sil_cell (
  input  logic                               clk,
  input  sil_pkg::chain_ctl_t                ctl,
  input  logic [sil_pkg::IDX_W-1:0]          idx,
  input  logic signed [sil_pkg::VALUE_W-1:0] prev_value,
  input  logic                               prev_ins,
  input  logic signed [sil_pkg::VALUE_W-1:0] next_value,
  input  logic signed [sil_pkg::VALUE_W-1:0] head_value,
  output logic signed [sil_pkg::VALUE_W-1:0] value,
  output logic                               ins
);
  import sil_pkg::*;

  logic wrap;

  // empty cells and cells not below the new value make room
  assign ins  = (CNT_W'(idx) >= ctl.count) || (value >= ctl.value);
  // last occupied cell takes the head during a rotate
  assign wrap = (CNT_W'(idx) + CNT_W'(1)) == ctl.count;

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_HOLD:   value <= value;
      OP_INSERT: begin
        if (prev_ins) begin
          value <= prev_value;
        end else if (ins) begin
          value <= ctl.value;
        end
      end
      OP_ROTATE: value <= wrap ? head_value : next_value;
      default:   value <= value;
    endcase
  end

endmodule

// File: rtl/core/sil_ctrl.sv
// controller: handshakes, entry count, display fsm and result register
// depends on sil_pkg and the channel interfaces
module sil_ctrl (
  input  logic                               clk,
  input  logic                               rst,
  sil_req_if.sink                            req,
  sil_rsp_if.source                          rsp,
  input  logic signed [sil_pkg::VALUE_W-1:0] head_value,
  output sil_pkg::chain_ctl_t                ctl
);
  import sil_pkg::*;

  state_t                    state, state_next;
  logic [CNT_W-1:0]          count, count_next;
  logic [IDX_W-1:0]          pos, pos_next;
  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_entry, out_entry_next;
  logic                      out_last, out_last_next;
  logic [STAT_W-1:0]         out_status, out_status_next;
  logic [COUNT_W-1:0]        out_count;
  logic [CNT_W-1:0]          out_count_next;
  logic                      out_load;
  logic                      out_free;
  logic                      req_fire;
  logic                      disp_last;
  logic                      full;

  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == ST_IDLE) && out_free;
  assign req_fire  = req.valid && req.ready;
  assign disp_last = (CNT_W'(pos) + CNT_W'(1)) == count;
  assign full      = count == CNT_W'(DEPTH);

  assign rsp.valid       = out_valid;
  assign rsp.entry_value = out_entry;
  assign rsp.last        = out_last;
  assign rsp.status      = out_status;
  assign rsp.count       = out_count;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_fire && req.command == CMD_DISPLAY && count != '0) begin
          state_next = ST_DISP;
        end
      end
      ST_DISP: begin
        if (out_free && disp_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    ctl.op          = OP_HOLD;
    ctl.value       = req.value;
    ctl.count       = count;
    count_next      = count;
    pos_next        = pos;
    out_load        = 1'b0;
    out_entry_next  = '0;
    out_last_next   = 1'b1;
    out_status_next = STATUS_OK;
    out_count_next  = count;
    unique case (state)
      ST_IDLE: begin
        pos_next = '0;
        if (req_fire) begin
          if (req.command == CMD_INSERT) begin
            out_load = 1'b1;
            if (full) begin
              out_status_next = STATUS_FULL;
            end else begin
              ctl.op         = OP_INSERT;
              count_next     = count + CNT_W'(1);
              out_count_next = count + CNT_W'(1);
            end
          end else if (count == '0) begin
            out_load        = 1'b1;
            out_status_next = STATUS_EMPTY;
          end
        end
      end
      ST_DISP: begin
        if (out_free) begin
          out_load       = 1'b1;
          out_entry_next = head_value;
          out_last_next  = disp_last;
          ctl.op         = OP_ROTATE;
          pos_next       = pos + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      pos       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      count <= count_next;
      pos   <= pos_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_entry  <= out_entry_next;
      out_last   <= out_last_next;
      out_status <= out_status_next;
      out_count  <= COUNT_W'(out_count_next);
    end
  end

endmodule

// File: rtl/core/sorted_insert_list_core.sv
// sorted insert list top level: controller plus a chain of storage cells
// depends on sil_pkg, sil_channels, sil_cell and sil_ctrl
//
// channel  dir  word contents                            handshake
// req      in   command, value                           valid/ready
// rsp      out  entry_value, last, status, count         valid/ready
//
// an insert updates the cell chain and gives one word
// a display of n entries first takes the command, then gives n words, one per cycle
//   while rsp does not stall, from the single head cell as the chain rotates
// req is taken only while no display is running and the result register
//   is free or being drained; a stall on rsp freezes the chain in place
// rst clears the count and control; cell contents need no reset
module sorted_insert_list_core (
  input  logic      clk,
  input  logic      rst,
  sil_req_if.sink   req,
  sil_rsp_if.source rsp
);
  import sil_pkg::*;

  // one broadcast control word for every cell
  chain_ctl_t                ctl;
  // cell contents, cell 0 holds the smallest value
  logic signed [VALUE_W-1:0] cell_value [DEPTH];
  // per-cell "this cell makes room" flags, monotonic along the chain
  logic                      cell_ins   [DEPTH];

  sil_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req        (req),
    .rsp        (rsp),
    .head_value (cell_value[0]),
    .ctl        (ctl)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VALUE_W-1:0] prev_v;
    logic                      prev_i;
    logic signed [VALUE_W-1:0] next_v;

    // left neighbor feeds a shift on insert; cell 0 has nobody to its left
    if (i == 0) begin : g_first
      assign prev_v = ctl.value;
      assign prev_i = 1'b0;
    end else begin : g_mid
      assign prev_v = cell_value[i-1];
      assign prev_i = cell_ins[i-1];
    end

    // right neighbor feeds a rotate; the end cell only ever wraps the head
    if (i == DEPTH - 1) begin : g_end
      assign next_v = cell_value[0];
    end else begin : g_body
      assign next_v = cell_value[i+1];
    end

    sil_cell u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .idx        (IDX_W'(i)),
      .prev_value (prev_v),
      .prev_ins   (prev_i),
      .next_value (next_v),
      .head_value (cell_value[0]),
      .value      (cell_value[i]),
      .ins        (cell_ins[i])
    );
  end

endmodule

// File: rtl/core/sil_checker.sv
// port-level checker for the sorted insert list, bound to the top level
// depends on sil_pkg and sorted_insert_list_core_assert.svh
`include "sorted_insert_list_core_assert.svh"

module sil_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               req_ready,
  input logic                               rsp_valid,
  input logic                               rsp_ready,
  input logic signed [sil_pkg::VALUE_W-1:0] rsp_entry_value,
  input logic                               rsp_last,
  input logic [sil_pkg::STAT_W-1:0]         rsp_status,
  input logic [sil_pkg::COUNT_W-1:0]        rsp_count
);
  import sil_pkg::*;

  // a word waiting on the sink keeps its value
  `SIL_ASSERT_NXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_entry_value) && $stable(rsp_last) && $stable(rsp_count))

  // mid-display words block new requests
  `SIL_ASSERT_IMP(a_disp_blocks, rsp_valid && !rsp_last, !req_ready)

  // empty answer is a lone zero word with count zero
  `SIL_ASSERT_IMP(a_empty_word, rsp_valid && rsp_status == STATUS_EMPTY, rsp_last && rsp_count == '0 && rsp_entry_value == '0)

  // full answer only with a full store
  `SIL_ASSERT_IMP(a_full_word, rsp_valid && rsp_status == STATUS_FULL, rsp_last && rsp_count == COUNT_W'(DEPTH))

endmodule

bind sorted_insert_list_core sil_checker u_sil_checker (
  .clk             (clk),
  .rst             (rst),
  .req_ready       (req.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .rsp_entry_value (rsp.entry_value),
  .rsp_last        (rsp.last),
  .rsp_status      (rsp.status),
  .rsp_count       (rsp.count)
);

// File: tb/testbench.sv
`timescale 1ns / 100ps
// testbench for sorted_insert_list_core: a directed table, then random words, each
// checked against a behavioral model of the sorted store through a queue of expected words
// depends on sil_pkg, sil_channels and the core rtl
module testbench;
  import sil_pkg::*;

  // one result word as the rsp channel carries it
  typedef struct packed {
    logic signed [VALUE_W-1:0] entry_value;
    logic                      last;
    logic [STAT_W-1:0]         status;
    logic [COUNT_W-1:0]        count;
  } list_word_t;

  // one row of the directed table; typed rows carry their answer in the row
  typedef struct packed {
    logic                      cmd;
    logic signed [VALUE_W-1:0] value;
    bit                        typed;
    list_word_t                want;
  } script_row_t;

  localparam int RANDOM_ITEMS  = 198;
  localparam int HOLD_CYCLES   = 60;      // long receiver hold-off
  localparam int DRAIN_CYCLES  = 40;      // quiet time after the last word
  localparam int LIMIT_CYCLES  = 400000;  // run limit for the whole test
  localparam int HOLD_AT_ITEM  = 60;      // random item that starts the hold-off
  localparam int PAUSE_AT_ITEM = 140;     // random item that waits for an empty queue

  logic clk;
  logic rst;

  sil_req_if req_ch ();
  sil_rsp_if rsp_ch ();

  sorted_insert_list_core dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // model of the store: ascending values and how many are held
  logic signed [VALUE_W-1:0] model_store [DEPTH];
  int                        model_count;

  list_word_t  pending_words [$];   // result words still owed by the block, oldest first
  script_row_t script [$];
  int          fault_count;
  int          burst_left;
  bit          hold_off_req;        // sender asks the receiver for a long hold-off
  int unsigned cycle_count;

  // clock, 20 ns period
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit, in case the block hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // word with no value and last set: inserts, full drops and the empty display
  function automatic list_word_t short_word(logic [STAT_W-1:0] st, int cnt);
    list_word_t w;
    w.entry_value = '0;
    w.last        = 1'b1;
    w.status      = st;
    w.count       = COUNT_W'(cnt);
    return w;
  endfunction

  function automatic void add_row(logic cmd, logic signed [VALUE_W-1:0] val, bit typed,
                                  logic [STAT_W-1:0] st, int cnt);
    script_row_t r;
    r.cmd   = cmd;
    r.value = val;
    r.typed = typed;
    r.want  = short_word(st, cnt);
    script.push_back(r);
  endfunction

  // advance the model by one accepted word and queue the words it owes
  function automatic void model_step(logic cmd, logic signed [VALUE_W-1:0] val);
    int         pos;
    int         i;
    list_word_t w;
    if (cmd == CMD_INSERT) begin
      if (model_count >= DEPTH) begin
        // full: value dropped, state untouched
        pending_words.push_back(short_word(STATUS_FULL, model_count));
      end else begin
        // goes ahead of the first held value that is not smaller
        pos = 0;
        while (pos < model_count && model_store[pos] < val)
          pos++;
        for (i = model_count; i > pos; i--)
          model_store[i] = model_store[i-1];
        model_store[pos] = val;
        model_count++;
        pending_words.push_back(short_word(STATUS_OK, model_count));
      end
    end else if (model_count == 0) begin
      pending_words.push_back(short_word(STATUS_EMPTY, 0));
    end else begin
      // display: every held value, smallest first, last on the final one
      for (i = 0; i < model_count; i++) begin
        w.entry_value = model_store[i];
        w.last        = (i == model_count - 1);
        w.status      = STATUS_OK;
        w.count       = COUNT_W'(model_count);
        pending_words.push_back(w);
      end
    end
  endfunction

  task automatic note_fault(string why, list_word_t want, list_word_t got);
    fault_count++;
    if (fault_count <= 10)
      $display("[%0t] %s: want value %0d last %0b status %0d count %0d", $realtime, why,
               want.entry_value, want.last, want.status, want.count,
               "; got value %0d last %0b status %0d count %0d",
               got.entry_value, got.last, got.status, got.count);
  endtask

  // offer one word and hold it until the block takes it; called at a clock edge
  task automatic send_word(logic cmd, logic signed [VALUE_W-1:0] val, bit typed,
                           list_word_t want);
    req_ch.valid   <= 1'b1;
    req_ch.command <= cmd;
    req_ch.value   <= val;
    @(posedge clk);
    while (!req_ch.ready)
      @(posedge clk);
    model_step(cmd, val);
    // typed rows: the model keeps its state, the row gives the answer
    if (typed) begin
      void'(pending_words.pop_back());
      pending_words.push_back(want);
    end
  endtask

  // sender pacing: bursts of random length, random gaps between them
  task automatic pace();
    int gap;
    if (burst_left > 0)
      burst_left--;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                               : $urandom_range(1, 12);
      if (gap > 0) begin
        req_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  // drop valid and sit until every owed word has come back
  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0)
      @(posedge clk);
  endtask

  // random value, leaning on the extremes and zero
  function automatic logic signed [VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'sh7FFF_FFFF;
      1:       return 32'sh8000_0000;
      2:       return '0;
      default: return $urandom();
    endcase
  endfunction

  // scoreboard: each word taken on rsp against the oldest owed word
  always @(posedge clk) begin : rsp_check
    list_word_t got;
    list_word_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got.entry_value = rsp_ch.entry_value;
      got.last        = rsp_ch.last;
      got.status      = rsp_ch.status;
      got.count       = rsp_ch.count;
      if (pending_words.size() == 0) begin
        note_fault("word with nothing owed", '0, got);
      end else begin
        want = pending_words.pop_front();
        if (got.entry_value !== want.entry_value || got.last !== want.last ||
            got.status !== want.status || got.count !== want.count)
          note_fault("word mismatch", want, got);
      end
    end
  end

  // receiver: ready follows an 8-bit pattern picked per stretch, all-ones
  // now and then for stall-free runs; a hold-off request wins over the pattern
  initial begin : rsp_drain
    logic [7:0] pat;
    int         run_len;
    int         k;
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst)
      @(posedge clk);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        pat = ($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom());
        if (pat == 8'h00)
          pat = 8'h01;
        run_len = $urandom_range(8, 48);
        for (k = 0; k < run_len && !hold_off_req; k++) begin
          rsp_ch.ready <= pat[k % 8];
          @(posedge clk);
        end
      end
    end
  end

  // stimulus
  initial begin : req_drive
    int         n;
    logic       cmd;
    list_word_t none;
    none         = '0;
    fault_count  = 0;
    model_count  = 0;
    burst_left   = 0;
    hold_off_req = 1'b0;
    cycle_count  = 0;

    // directed table: empty store, extremes, equal values, filling up, full drops
    add_row(CMD_DISPLAY, 32'shFFFF_FFFF, 1, STATUS_EMPTY, 0);  // value ignored
    add_row(CMD_INSERT,  32'sh7FFF_FFFF, 1, STATUS_OK,    1);
    add_row(CMD_INSERT,  32'sh8000_0000, 1, STATUS_OK,    2);
    add_row(CMD_INSERT,  32'sh0000_0000, 1, STATUS_OK,    3);
    add_row(CMD_INSERT,  32'shFFFF_FFFF, 1, STATUS_OK,    4);
    add_row(CMD_INSERT,  32'sh0000_0000, 1, STATUS_OK,    5);  // equal to a held value
    add_row(CMD_INSERT,  32'sh0000_0001, 1, STATUS_OK,    6);
    add_row(CMD_DISPLAY, 32'sh0000_0000, 0, STATUS_OK,    0);
    add_row(CMD_INSERT,  32'sh7FFF_FFFF, 1, STATUS_OK,    7);  // second max
    add_row(CMD_INSERT,  32'sh8000_0000, 1, STATUS_OK,    8);  // second min
    add_row(CMD_INSERT,  32'sh5555_5555, 1, STATUS_OK,    9);
    add_row(CMD_INSERT,  32'shAAAA_AAAA, 1, STATUS_OK,    10);
    add_row(CMD_INSERT,  32'shFFFF_FFFF, 1, STATUS_OK,    11);
    add_row(CMD_INSERT,  32'sh0000_FFFF, 1, STATUS_OK,    12);
    add_row(CMD_INSERT,  32'shFFFF_0000, 1, STATUS_OK,    13);
    add_row(CMD_INSERT,  32'sh7FFF_FFFE, 1, STATUS_OK,    14);
    add_row(CMD_DISPLAY, 32'sh1234_5678, 0, STATUS_OK,    0);
    add_row(CMD_INSERT,  32'sh8000_0001, 1, STATUS_OK,    15);
    add_row(CMD_INSERT,  32'sh1234_5678, 1, STATUS_OK,    16);  // now full
    add_row(CMD_INSERT,  32'sh0000_0000, 1, STATUS_FULL,  16);
    add_row(CMD_INSERT,  32'sh7FFF_FFFF, 1, STATUS_FULL,  16);
    add_row(CMD_DISPLAY, 32'sh0000_0000, 0, STATUS_OK,    0);   // all sixteen

    rst            <= 1'b1;
    req_ch.valid   <= 1'b0;
    req_ch.command <= CMD_INSERT;
    req_ch.value   <= '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (script[i]) begin
      send_word(script[i].cmd, script[i].value, script[i].typed, script[i].want);
      pace();
    end

    // random part: the store stays full, so inserts check the drop path with
    // random values and displays check the whole ordered store
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == PAUSE_AT_ITEM)
        wait_drained();
      if (n == HOLD_AT_ITEM) begin
        // receiver holds off while the sender keeps offering back to back
        hold_off_req = 1'b1;
        burst_left   = 30;
      end
      cmd = $urandom_range(0, 1) ? CMD_DISPLAY : CMD_INSERT;
      send_word(cmd, pick_value(), 0, none);
      pace();
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fault_count == 0 && pending_words.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/sil_pkg.sv
rtl/core/sil_channels.sv
rtl/core/sil_cell.sv
rtl/core/sil_ctrl.sv
rtl/core/sorted_insert_list_core.sv
rtl/core/sil_checker.sv
tb/testbench.sv
